FILE: hw/rtl/icns_best_png_chunk_finder_core_defines.svh
// ---------------------------------------------------------------------------
// icns chunk finder assertion macros
// shared concurrent assertion forms, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ICNS_BEST_PNG_CHUNK_FINDER_CORE_DEFINES_SVH
`define ICNS_BEST_PNG_CHUNK_FINDER_CORE_DEFINES_SVH

// property holds at every clock edge outside reset
`define ICNSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ICNSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/icnsf_pkg.sv
// ---------------------------------------------------------------------------
// icns chunk finder package
// shared widths, tag table, png signature and result types
// ---------------------------------------------------------------------------
package icnsf_pkg;

  localparam int TAG_COUNT   = 8;
  localparam int OFFSET_BITS = 32;

  localparam int RankBits = $clog2(TAG_COUNT + 1);
  localparam int ExtBits  = 33;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [RankBits-1:0]    rank_t;
  typedef logic [ExtBits-1:0]     ext_t;

  localparam logic [31:0] OffMax32  = 32'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [31:0] MagicWord = 32'h69636E73;
  localparam logic [3:0]  SigLen    = 4'd8;
  localparam logic [3:0]  SigDead   = 4'hF;

  localparam logic [31:0] TagTable [8] = '{
    32'h69633130, 32'h69633134, 32'h69633039, 32'h69633133,
    32'h69633038, 32'h69633132, 32'h69633037, 32'h69633131
  };

  localparam logic [7:0] PngSig [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadHeader = 2'd1,
    StNoPng     = 2'd2,
    StBadSig    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  rank;
    logic [31:0] data_size;
    logic [31:0] data_offset;
    status_e     status;
  } result_t;

  function automatic rank_t tag_rank(input logic [31:0] tag);
    rank_t r;
    r = rank_t'(TAG_COUNT);
    for (int i = TAG_COUNT - 1; i >= 0; i--) begin
      if (TagTable[i] == tag) begin
        r = rank_t'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/icns_best_png_chunk_finder_core.sv
// a final byte is held in the input register, then its result in the output register
// throughput: one byte per cycle, set by the single parser step per byte
// a final byte waits only while the previous result is not yet taken
// reset: asynchronous active low, parser returns to the file header state
// the parser also returns to that state after each final byte
// ---------------------------------------------------------------------------
// icns best png chunk finder
// streams an icon container file and reports its best png chunk
// ---------------------------------------------------------------------------
module icns_best_png_chunk_finder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // file_byte[7:0]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // status[1:0], data_offset[33:2],
                                      // data_size[65:34], rank[68:66], zero[71:69]
);

  icnsf_pkg::item_t   in_item;
  icnsf_pkg::item_t   step_item;
  logic               step;
  logic               out_free;
  logic               res_valid;
  icnsf_pkg::result_t res;

  assign in_item = '{file_byte: s_axis_tdata, last_byte: s_axis_tlast};

  icnsf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .item_i     (in_item),
    .out_free_i (out_free),
    .step_o     (step),
    .item_o     (step_item)
  );

  icnsf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (step_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  icnsf_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .out_free_o (out_free),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (m_axis_tdata)
  );

endmodule

FILE: hw/rtl/icnsf_in_stage.sv
// ---------------------------------------------------------------------------
// icns chunk finder input stage
// registers one incoming byte and releases it to the parser
// ---------------------------------------------------------------------------
module icnsf_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  icnsf_pkg::item_t item_i,
  input  logic            out_free_i,
  output logic            step_o,
  output icnsf_pkg::item_t item_o
);

  logic             valid_q, valid_d;
  icnsf_pkg::item_t item_q;

  // a last byte needs a free result slot, any other byte moves on at once
  assign step_o  = valid_q && (!item_q.last_byte || out_free_i);
  assign ready_o = !valid_q || step_o;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: hw/rtl/icnsf_parser.sv
// ---------------------------------------------------------------------------
// icns chunk finder parser
// container header check, chunk walk, png signature check and best pick
// ---------------------------------------------------------------------------
`include "icns_best_png_chunk_finder_core_defines.svh"

module icnsf_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  icnsf_pkg::item_t   item_i,
  output logic               res_valid_o,
  output icnsf_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PhHeader   = 3'd0,
    PhChunkHdr = 3'd1,
    PhBody     = 3'd2,
    PhDone     = 3'd3,
    PhBad      = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  icnsf_pkg::off_t   pos_q, pos_d;
  icnsf_pkg::off_t   decl_q, decl_d;
  logic [63:0]       hdr_q, hdr_d;
  icnsf_pkg::ext_t   cend_q, cend_d;
  icnsf_pkg::rank_t  cur_rank_q, cur_rank_d;
  logic [3:0]        sig_q, sig_d;
  logic              sig_good_q, sig_good_d;
  icnsf_pkg::rank_t  best_rank_q, best_rank_d;
  icnsf_pkg::off_t   best_off_q, best_off_d;
  icnsf_pkg::off_t   best_size_q, best_size_d;
  logic              best_sig_q, best_sig_d;

  icnsf_pkg::off_t   count;
  icnsf_pkg::ext_t   count_x;
  logic [63:0]       hdr_shift;
  logic [31:0]       hdr_size;
  logic [31:0]       decl_new;
  icnsf_pkg::ext_t   cend_new;
  icnsf_pkg::ext_t   fin_size;
  logic              fin;
  icnsf_pkg::result_t res;

  assign count     = (pos_q == '1) ? pos_q : pos_q + icnsf_pkg::off_t'(1);
  assign count_x   = icnsf_pkg::ext_t'(count);
  assign hdr_shift = {hdr_q[55:0], item_i.file_byte};
  assign hdr_size  = hdr_shift[31:0];
  assign decl_new  = (hdr_size > icnsf_pkg::OffMax32) ? icnsf_pkg::OffMax32 : hdr_size;
  assign cend_new  = cend_q + icnsf_pkg::ext_t'(hdr_size);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    decl_d      = decl_q;
    hdr_d       = hdr_q;
    cend_d      = cend_q;
    cur_rank_d  = cur_rank_q;
    sig_d       = sig_q;
    sig_good_d  = sig_good_q;
    best_rank_d = best_rank_q;
    best_off_d  = best_off_q;
    best_size_d = best_size_q;
    best_sig_d  = best_sig_q;
    fin         = 1'b0;
    fin_size    = '0;
    res         = '{rank: '0, data_size: '0, data_offset: '0,
                    status: icnsf_pkg::StBadHeader};

    if (step_i) begin
      pos_d = count;
      unique case (phase_q)
        PhHeader: begin
          hdr_d = hdr_shift;
          if (count == icnsf_pkg::off_t'(4) && hdr_size != icnsf_pkg::MagicWord) begin
            phase_d = PhBad;
          end else if (count == icnsf_pkg::off_t'(8)) begin
            decl_d  = icnsf_pkg::off_t'(decl_new);
            cend_d  = icnsf_pkg::ext_t'(8);
            hdr_d   = '0;
            phase_d = (icnsf_pkg::ext_t'(16) > icnsf_pkg::ext_t'(decl_new)) ?
                      PhDone : PhChunkHdr;
          end
        end
        PhChunkHdr: begin
          hdr_d = hdr_shift;
          if (count_x == cend_q + icnsf_pkg::ext_t'(8)) begin
            if (hdr_size < 32'd8 || cend_new > icnsf_pkg::ext_t'(decl_q)) begin
              phase_d = PhDone;
            end else begin
              cur_rank_d = icnsf_pkg::tag_rank(hdr_shift[63:32]);
              cend_d     = cend_new;
              sig_d      = '0;
              sig_good_d = 1'b0;
              if (count_x == cend_new) begin
                fin = 1'b1;
              end else begin
                phase_d = PhBody;
              end
            end
          end
        end
        PhBody: begin
          if (sig_q < icnsf_pkg::SigLen) begin
            if (item_i.file_byte == icnsf_pkg::PngSig[sig_q[2:0]]) begin
              sig_d = sig_q + 4'd1;
              if (sig_q == icnsf_pkg::SigLen - 4'd1) begin
                sig_good_d = 1'b1;
              end
            end else begin
              sig_d = icnsf_pkg::SigDead;
            end
          end
          if (count_x == cend_q) begin
            fin = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // chunk complete: keep it if its rank beats the best so far
      if (fin) begin
        fin_size = icnsf_pkg::ext_t'(hdr_d[31:0]);
        if (cur_rank_d < best_rank_q) begin
          best_rank_d = cur_rank_d;
          best_size_d = icnsf_pkg::off_t'(fin_size - icnsf_pkg::ext_t'(8));
          best_off_d  = icnsf_pkg::off_t'(cend_d - fin_size + icnsf_pkg::ext_t'(8));
          best_sig_d  = sig_good_d;
        end
        if (cur_rank_d < best_rank_q && cur_rank_d == '0) begin
          phase_d = PhDone;
        end else begin
          hdr_d   = '0;
          phase_d = (cend_d + icnsf_pkg::ext_t'(8) > icnsf_pkg::ext_t'(decl_q)) ?
                    PhDone : PhChunkHdr;
        end
      end

      if (phase_d == PhBad || phase_d == PhHeader) begin
        res.status = icnsf_pkg::StBadHeader;
      end else if (best_rank_d >= icnsf_pkg::rank_t'(icnsf_pkg::TAG_COUNT) ||
                   best_size_d == '0) begin
        res.status = icnsf_pkg::StNoPng;
      end else begin
        res.status      = best_sig_d ? icnsf_pkg::StOk : icnsf_pkg::StBadSig;
        res.data_offset = 32'(best_off_d);
        res.data_size   = 32'(best_size_d);
        res.rank        = 3'(best_rank_d);
      end

      // end of file: start over for the next one
      if (item_i.last_byte) begin
        phase_d     = PhHeader;
        pos_d       = '0;
        decl_d      = '0;
        hdr_d       = '0;
        cend_d      = icnsf_pkg::ext_t'(8);
        cur_rank_d  = icnsf_pkg::rank_t'(icnsf_pkg::TAG_COUNT);
        sig_d       = '0;
        sig_good_d  = 1'b0;
        best_rank_d = icnsf_pkg::rank_t'(icnsf_pkg::TAG_COUNT);
        best_off_d  = '0;
        best_size_d = '0;
        best_sig_d  = 1'b0;
      end
    end
  end

  assign res_valid_o = step_i && item_i.last_byte;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      pos_q       <= '0;
      decl_q      <= '0;
      hdr_q       <= '0;
      cend_q      <= icnsf_pkg::ext_t'(8);
      cur_rank_q  <= icnsf_pkg::rank_t'(icnsf_pkg::TAG_COUNT);
      sig_q       <= '0;
      sig_good_q  <= 1'b0;
      best_rank_q <= icnsf_pkg::rank_t'(icnsf_pkg::TAG_COUNT);
      best_off_q  <= '0;
      best_size_q <= '0;
      best_sig_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      decl_q      <= decl_d;
      hdr_q       <= hdr_d;
      cend_q      <= cend_d;
      cur_rank_q  <= cur_rank_d;
      sig_q       <= sig_d;
      sig_good_q  <= sig_good_d;
      best_rank_q <= best_rank_d;
      best_off_q  <= best_off_d;
      best_size_q <= best_size_d;
      best_sig_q  <= best_sig_d;
    end
  end

  `ICNSF_ASSERT_NEXT(a_restart_after_result, res_valid_o,
                     phase_q == PhHeader && pos_q == '0, "parser did not restart after result")
  `ICNSF_ASSERT(a_best_rank_range, best_rank_q <= icnsf_pkg::rank_t'(icnsf_pkg::TAG_COUNT),
                "best rank out of range")
  `ICNSF_ASSERT(a_sig_progress_code, sig_q <= icnsf_pkg::SigLen || sig_q == icnsf_pkg::SigDead,
                "signature progress holds an unused code")
  `ICNSF_ASSERT(a_body_before_end, phase_q != PhBody || cend_q > icnsf_pkg::ext_t'(pos_q),
                "payload walk passed the chunk end")

endmodule

FILE: hw/rtl/icnsf_out_stage.sv
// ---------------------------------------------------------------------------
// icns chunk finder output stage
// result register with stream handshake and tdata packing
// ---------------------------------------------------------------------------
module icnsf_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  icnsf_pkg::result_t res_i,
  output logic               out_free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [71:0]        data_o
);

  logic               valid_q, valid_d;
  icnsf_pkg::result_t res_q;

  assign out_free_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign data_o     = {3'b000, res_q.rank, res_q.data_size, res_q.data_offset,
                       res_q.status};

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
